// File: hw/rtl/mssc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multiplexed seven-segment scanner.
// No dependencies; imported by mssc_engine and the top level.
package mssc_pkg;

    localparam int MAX_DIGITS = 4;

    localparam logic [1:0] FUNC_REFRESH = 2'd0;
    localparam logic [1:0] FUNC_WRITE   = 2'd1;
    localparam logic [1:0] FUNC_TOGGLE  = 2'd2;

    localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
    localparam logic [1:0] REG_FLASH_FIRST  = 2'd1;
    localparam logic [1:0] REG_FLASH_LAST   = 2'd2;
    localparam logic [1:0] REG_FLASH_PERIOD = 2'd3;

    localparam logic [2:0] COUNT_RESET = 3'd4;
    localparam logic [7:0] SEG_BLANK   = 8'h00;
    localparam logic [7:0] SEG_POINT   = 8'h80;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] position;
        logic [3:0] bcd_value;
        logic       first_digit;
        logic [1:0] range_low;
        logic [1:0] range_high;
    } in_word_t;

    typedef struct packed {
        logic [1:0] digit_select;
        logic [7:0] segments;
    } out_word_t;

    typedef struct packed {
        logic      emit;
        out_word_t word;
    } mssc_res_t;

    function automatic logic [7:0] bcd_to_seg(input logic [3:0] bcd);
        logic [7:0] seg;
        unique case (bcd)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [2:0] clamp_count(input logic [2:0] v);
        logic [2:0] c;
        if (v == 3'd0)
        begin
            c = 3'd1;
        end
        else if (v > 3'(MAX_DIGITS))
        begin
            c = 3'(MAX_DIGITS);
        end
        else
        begin
            c = v;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/mssc_engine.sv
`timescale 1ns / 1ps
// Display state, configuration registers and per-word update logic of the scanner.
// Depends on mssc_pkg; instantiated by multiplexed_seven_segment_scanner_top.
module mssc_engine
    import mssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        step,
    input  in_word_t    item,
    output mssc_res_t   result
);

    logic [7:0]  images_reg [MAX_DIGITS];
    logic [7:0]  images_next [MAX_DIGITS];
    logic [1:0]  active_reg;
    logic [1:0]  active_next;
    logic [15:0] frame_reg;
    logic [15:0] frame_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic [1:0]  first_reg;
    logic [1:0]  first_next;
    logic [1:0]  last_reg;
    logic [1:0]  last_next;
    logic [15:0] period_reg;
    logic [15:0] period_next;

    logic [2:0]  act_inc;
    logic [1:0]  act_wrap;
    logic [15:0] frame_inc;
    logic [15:0] frame_tick;
    logic [15:0] frame_new;
    logic        blank;
    logic [2:0]  new_count;

    always_comb
    begin
        act_inc    = {1'b0, active_reg} + 3'd1;
        act_wrap   = (act_inc >= count_reg) ? 2'd0 : act_inc[1:0];
        frame_inc  = frame_reg + 16'd1;
        frame_tick = (frame_inc >= period_reg) ? 16'd0 : frame_inc;
        frame_new  = (act_wrap == 2'd0) ? frame_tick : frame_reg;
        blank      = (period_reg != 16'd0) && (frame_new > (period_reg >> 1))
                     && (act_wrap >= first_reg) && (act_wrap <= last_reg);
        new_count  = clamp_count(cfg_data[2:0]);

        result.emit              = step && (item.func == FUNC_REFRESH);
        result.word.digit_select = act_wrap;
        result.word.segments     = blank ? SEG_BLANK : images_reg[act_wrap];

        images_next = images_reg;
        active_next = active_reg;
        frame_next  = frame_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        period_next = period_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIGIT_COUNT:
                begin
                    count_next  = new_count;
                    active_next = 2'(new_count - 3'd1);
                end
                REG_FLASH_FIRST:
                begin
                    first_next = cfg_data[1:0];
                    frame_next = 16'd0;
                end
                REG_FLASH_LAST:
                begin
                    last_next  = cfg_data[1:0];
                    frame_next = 16'd0;
                end
                REG_FLASH_PERIOD:
                begin
                    period_next = cfg_data;
                    frame_next  = 16'd0;
                end
                default:
                begin
                end
            endcase
        end
        else if (step)
        begin
            unique case (item.func)
                FUNC_REFRESH:
                begin
                    active_next = act_wrap;
                    frame_next  = frame_new;
                end
                FUNC_WRITE:
                begin
                    if (item.first_digit)
                    begin
                        for (int i = 0; i < MAX_DIGITS; i++)
                        begin
                            images_next[i] = SEG_BLANK;
                        end
                    end
                    if ({1'b0, item.position} < count_reg)
                    begin
                        images_next[item.position] = bcd_to_seg(item.bcd_value);
                    end
                end
                FUNC_TOGGLE:
                begin
                    for (int i = 0; i < MAX_DIGITS; i++)
                    begin
                        if ((2'(i) >= item.range_low) && (2'(i) <= item.range_high))
                        begin
                            images_next[i] = images_reg[i] ^ SEG_POINT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                images_reg[i] <= SEG_BLANK;
            end
            active_reg <= 2'(COUNT_RESET - 3'd1);
            frame_reg  <= 16'd0;
            count_reg  <= COUNT_RESET;
            first_reg  <= 2'd0;
            last_reg   <= 2'd0;
            period_reg <= 16'd0;
        end
        else
        begin
            images_reg <= images_next;
            active_reg <= active_next;
            frame_reg  <= frame_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            period_reg <= period_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= 3'd1) && (count_reg <= 3'(MAX_DIGITS)))
        else $error("digit count out of range");

    a_active_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, active_reg} < count_reg)
        else $error("active digit not below digit count");

    a_frame_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (period_reg == 16'd0) ? (frame_reg == 16'd0) : (frame_reg < period_reg))
        else $error("frame counter outside blink period");

    a_emit_follows_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (result.emit && !cfg_we && (result.word.digit_select == 2'd0)
            && (period_reg != 16'd0))
        |=> (frame_reg == $past(frame_tick)))
        else $error("frame counter did not advance on frame wrap");
`endif

endmodule

// File: hw/rtl/multiplexed_seven_segment_scanner_top.sv
`timescale 1ns / 1ps
// Top level of the multiplexed seven-segment scanner: input and result registers.
// Depends on mssc_pkg and mssc_engine.
//
//   Channel   Signals                          Direction  Word
//   in        in_valid, in_ready, in_data      in         in_word_t
//   out       out_valid, out_ready, out_data   out        out_word_t
//   cfg       cfg_we, cfg_index, cfg_data      in         16-bit register write
//
// One word is accepted per cycle unless the input register stalls; a refresh result
// goes via the input register into the result register, where it waits to be taken.
// The input register waits only on a refresh while a full result register is not read.
// Write and toggle words produce no result and never stall on the output side.
// Reset is asynchronous; digit store, settings and valid flags clear at once, no sweep.
module multiplexed_seven_segment_scanner_top
    import mssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_word_t  s1_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;
    logic      out_free;
    logic      s1_go;
    logic      in_fire;
    mssc_res_t res;

    mssc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (s1_go),
        .item      (s1_word_reg),
        .result    (res)
    );

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        s1_go    = s1_valid_reg && ((s1_word_reg.func != FUNC_REFRESH) || out_free);
        in_ready = !s1_valid_reg || s1_go;
        in_fire  = in_valid && in_ready;

        s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

        if (res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= in_data;
        end
        if (res.emit)
        begin
            out_word_reg <= res.word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |-> out_free)
        else $error("result register overwritten while full");

    a_emit_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |-> (s1_valid_reg && (s1_word_reg.func == FUNC_REFRESH)))
        else $error("result produced without a refresh word");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_word_reg)))
        else $error("input register lost a stalled word");
`endif

endmodule
